### src/lhm_pkg.sv
// shared constants, types and helpers for the latency histogram monitor
package lhm_pkg;

   localparam int NUM_BUCKETS = 32;
   localparam int NUM_STAGES  = 5;

   localparam int STG_AW  = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int BIDX_W  = $clog2(NUM_BUCKETS);
   localparam int BKT_DEPTH = NUM_STAGES * NUM_BUCKETS;
   localparam int BKT_AW  = (BKT_DEPTH > 1) ? $clog2(BKT_DEPTH) : 1;
   localparam int PROD_W  = 71;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [6:0] PCT_50  = 7'd50;
   localparam logic [6:0] PCT_95  = 7'd95;
   localparam logic [6:0] PCT_99  = 7'd99;
   localparam logic [6:0] PCT_ALL = 7'd100;

   typedef struct packed {
      logic [1:0]  op;
      logic [2:0]  stage;
      logic [63:0] elapsed;
   } req_type;

   typedef struct packed {
      logic [63:0] sample_count;
      logic [63:0] total_time;
      logic [63:0] min_time;
      logic [63:0] max_time;
      logic [63:0] p50_time;
      logic [63:0] p95_time;
      logic [63:0] p99_time;
   } rsp_type;

   typedef struct packed {
      logic [63:0] count;
      logic [63:0] total;
      logic [63:0] min;
      logic [63:0] max;
   } stats_type;

   localparam int STATS_W = $bits(stats_type);

   // ceiling of log2, saturated at the last bucket
   function automatic logic [BIDX_W-1:0] bucket_of(input logic [63:0] x);
      logic [63:0] xm1;
      int b;
      xm1 = x - 64'd1;
      b = 0;
      for (int i = 0; i < 64; i++) begin
         if (xm1[i]) b = i + 1;
      end
      if (x <= 64'd1) b = 0;
      if (b > NUM_BUCKETS - 1) b = NUM_BUCKETS - 1;
      return BIDX_W'(b);
   endfunction

   function automatic logic [63:0] bucket_bound(input logic [BIDX_W-1:0] idx);
      logic [63:0] v;
      if (int'(idx) == NUM_BUCKETS - 1) v = '1;
      else v = 64'd1 << idx;
      return v;
   endfunction

endpackage

### src/latency_histogram_monitor_top.sv
// latency histogram monitor top level
//
//  channel  ports                          direction  handshake
//  req      start, busy, req_data          in         start & !busy
//  rsp      rsp_valid, rsp_data            out        one-cycle strobe
//  csr      csr_valid, csr_ready, csr_data in         valid & ready
//
// record: stats and bucket ram read in ST_REC1, then write back in ST_REC2
// query: ST_LOAD reads the stats, then ST_WALK steps over the bucket ram, one entry a cycle
// clear and reset: ST_CLEAR sweeps the bucket ram, busy high
// results cannot be stalled; csr writes are always ready
module latency_histogram_monitor_top
   import lhm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_REC1  = 6'b000010,
      ST_REC2  = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_WALK  = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic      enable_ff, enable_in;
   logic [BKT_AW-1:0] clr_ff, clr_in;
   logic [BIDX_W-1:0] idx_ff, idx_in;
   logic [BIDX_W-1:0] bkt_ff, bkt_in;
   stats_type st_ff, st_in;
   logic [PROD_W-1:0] cum_ff, cum_in;
   logic [PROD_W-1:0] t50_ff, t50_in, t95_ff, t95_in, t99_ff, t99_in;
   logic [2:0]  found_ff, found_in;
   logic [63:0] p50_ff, p50_in, p95_ff, p95_in, p99_ff, p99_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   logic in_range;
   logic [STG_AW-1:0] stg;
   logic [BKT_AW-1:0] base;

   logic              stats_we;
   logic [STG_AW-1:0] stats_waddr, stats_raddr;
   stats_type         stats_wdata, stats_rdata;
   logic              bkt_we;
   logic [BKT_AW-1:0] bkt_waddr, bkt_raddr;
   logic [63:0]       bkt_wdata, bkt_rdata;

   logic [PROD_W-1:0] cum_n;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign stg       = STG_AW'(req_ff.stage);
   assign in_range  = ({29'd0, req_data.stage} < 32'(NUM_STAGES));
   assign base      = BKT_AW'(int'(stg) * NUM_BUCKETS);
   assign cum_n     = cum_ff + PROD_W'(bkt_rdata) * PROD_W'(PCT_ALL);

   lhm_ram #(.WIDTH(STATS_W), .DEPTH(NUM_STAGES)) u_stats_ram (
      .clock   (clock),
      .wr_en   (stats_we),
      .wr_addr (stats_waddr),
      .wr_data (stats_wdata),
      .rd_addr (stats_raddr),
      .rd_data (stats_rdata)
   );

   lhm_ram #(.WIDTH(64), .DEPTH(BKT_DEPTH)) u_bkt_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      enable_in    = enable_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      bkt_in       = bkt_ff;
      st_in        = st_ff;
      cum_in       = cum_ff;
      t50_in       = t50_ff;
      t95_in       = t95_ff;
      t99_in       = t99_ff;
      found_in     = found_ff;
      p50_in       = p50_ff;
      p95_in       = p95_ff;
      p99_in       = p99_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      stats_we     = 1'b0;
      stats_waddr  = stg;
      stats_wdata  = st_ff;
      stats_raddr  = STG_AW'(req_data.stage);
      bkt_we       = 1'b0;
      bkt_waddr    = base + BKT_AW'(bkt_ff);
      bkt_wdata    = bkt_rdata + 64'd1;
      bkt_raddr    = base + BKT_AW'(bkt_ff);

      if (csr_valid && csr_ready) enable_in = csr_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               unique case (req_data.op)
                  OP_RECORD: if (enable_ff && in_range) state_in = ST_REC1;
                  OP_QUERY: begin
                     if (in_range) begin
                        state_in = ST_LOAD;
                     end else begin
                        rsp_in       = '0;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = ST_CLEAR;
                     clr_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_REC1: begin
            bkt_in      = bucket_of(req_ff.elapsed);
            stats_raddr = stg;
            bkt_raddr   = base + BKT_AW'(bucket_of(req_ff.elapsed));
            state_in    = ST_REC2;
         end
         ST_REC2: begin
            stats_we          = 1'b1;
            stats_wdata.count = stats_rdata.count + 64'd1;
            stats_wdata.total = stats_rdata.total + req_ff.elapsed;
            stats_wdata.min   = (req_ff.elapsed < stats_rdata.min) ?
                                req_ff.elapsed : stats_rdata.min;
            stats_wdata.max   = (req_ff.elapsed > stats_rdata.max) ?
                                req_ff.elapsed : stats_rdata.max;
            bkt_we            = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_LOAD: begin
            // compare 100 * cumulative against count * p, same as ceil target
            st_in    = stats_rdata;
            t50_in   = PROD_W'(stats_rdata.count) * PROD_W'(PCT_50);
            t95_in   = PROD_W'(stats_rdata.count) * PROD_W'(PCT_95);
            t99_in   = PROD_W'(stats_rdata.count) * PROD_W'(PCT_99);
            cum_in   = '0;
            found_in = '0;
            p50_in   = stats_rdata.max;
            p95_in   = stats_rdata.max;
            p99_in   = stats_rdata.max;
            idx_in   = '0;
            bkt_raddr = base;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            cum_in    = cum_n;
            bkt_raddr = base + BKT_AW'(idx_ff) + BKT_AW'(1);
            if (!found_ff[0] && cum_n >= t50_ff) begin
               found_in[0] = 1'b1;
               p50_in      = bucket_bound(idx_ff);
            end
            if (!found_ff[1] && cum_n >= t95_ff) begin
               found_in[1] = 1'b1;
               p95_in      = bucket_bound(idx_ff);
            end
            if (!found_ff[2] && cum_n >= t99_ff) begin
               found_in[2] = 1'b1;
               p99_in      = bucket_bound(idx_ff);
            end
            if (int'(idx_ff) == NUM_BUCKETS - 1) begin
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_in.sample_count  = st_ff.count;
               rsp_in.total_time    = st_ff.total;
               rsp_in.min_time      = (st_ff.count == 64'd0) ? 64'd0 : st_ff.min;
               rsp_in.max_time      = st_ff.max;
               rsp_in.p50_time      = (st_ff.count == 64'd0) ? 64'd0 : p50_in;
               rsp_in.p95_time      = (st_ff.count == 64'd0) ? 64'd0 : p95_in;
               rsp_in.p99_time      = (st_ff.count == 64'd0) ? 64'd0 : p99_in;
            end else begin
               idx_in = idx_ff + BIDX_W'(1);
            end
         end
         ST_CLEAR: begin
            bkt_we      = 1'b1;
            bkt_waddr   = clr_ff;
            bkt_wdata   = '0;
            stats_waddr = STG_AW'(clr_ff);
            stats_wdata = '{count: 64'd0, total: 64'd0, min: '1, max: 64'd0};
            stats_we    = (int'(clr_ff) < NUM_STAGES);
            if (int'(clr_ff) == BKT_DEPTH - 1) state_in = ST_IDLE;
            else clr_in = clr_ff + BKT_AW'(1);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      idx_ff   <= idx_in;
      bkt_ff   <= bkt_in;
      st_ff    <= st_in;
      cum_ff   <= cum_in;
      t50_ff   <= t50_in;
      t95_ff   <= t95_in;
      t99_ff   <= t99_in;
      found_ff <= found_in;
      p50_ff   <= p50_in;
      p95_ff   <= p95_in;
      p99_ff   <= p99_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_bkt_write_state: assert property (@(posedge clock) disable iff (reset)
      bkt_we |-> (state_ff == ST_REC2 || state_ff == ST_CLEAR))
      else $error("bucket ram written outside record or clear");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == ST_CLEAR && clr_ff == '0))
      else $error("reset did not start clearing sweep");

   a_walk_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && int'(idx_ff) == NUM_BUCKETS - 1) |=>
      (rsp_valid && state_ff == ST_IDLE))
      else $error("query walk ended without a result");

   a_record_writeback: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REC1) |=> (stats_we && bkt_we))
      else $error("record did not write back");
`endif

endmodule

### src/lhm_ram.sv
// generic single-port-write ram with registered read
module lhm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### dv/latency_histogram_checker.sv
// checker that predicts latency histogram statistics and compares query results
`timescale 1ns / 100ps
module latency_histogram_checker
   import lhm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_data,
   output int      error_count,
   output int      pending_queries,
   output int      queries_seen
);

   logic        record_enable;
   logic [63:0] lat_count [NUM_STAGES];
   logic [63:0] lat_total [NUM_STAGES];
   logic [63:0] lat_min   [NUM_STAGES];
   logic [63:0] lat_max   [NUM_STAGES];
   logic [63:0] hist      [NUM_STAGES][NUM_BUCKETS];
   rsp_type     expected_stats [$];

   function automatic int log2_bucket(input logic [63:0] x);
      int b;
      b = 0;
      while (x > 64'd1 && b + 1 < NUM_BUCKETS) begin
         x = (x >> 1) + {63'd0, x[0]};
         b++;
      end
      return b;
   endfunction

   function automatic logic [63:0] percentile_bound(input int s, input logic [63:0] p);
      logic [63:0] target;
      logic [63:0] cum;
      if (lat_count[s] == 0) return 64'd0;
      target = (lat_count[s] / 100) * p + ((lat_count[s] % 100) * p + 99) / 100;
      cum = 0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
         cum += hist[s][b];
         if (cum >= target) begin
            if (b == NUM_BUCKETS - 1) return '1;
            return 64'd1 << b;
         end
      end
      return lat_max[s];
   endfunction

   task automatic clear_stats();
      for (int s = 0; s < NUM_STAGES; s++) begin
         lat_count[s] = 0;
         lat_total[s] = 0;
         lat_min[s] = '1;
         lat_max[s] = 0;
         for (int b = 0; b < NUM_BUCKETS; b++) hist[s][b] = 0;
      end
   endtask

   task automatic apply_request(input req_type r);
      rsp_type e;
      int s;
      s = int'(r.stage);
      case (r.op)
         OP_CLEAR: begin
            clear_stats();
         end
         OP_RECORD: begin
            if (record_enable && s < NUM_STAGES) begin
               lat_count[s] += 1;
               lat_total[s] += r.elapsed;
               hist[s][log2_bucket(r.elapsed)] += 1;
               if (r.elapsed < lat_min[s]) lat_min[s] = r.elapsed;
               if (r.elapsed > lat_max[s]) lat_max[s] = r.elapsed;
            end
         end
         OP_QUERY: begin
            e = '0;
            if (s < NUM_STAGES) begin
               e.sample_count = lat_count[s];
               e.total_time = lat_total[s];
               e.min_time = (lat_count[s] == 0) ? 64'd0 : lat_min[s];
               e.max_time = lat_max[s];
               e.p50_time = percentile_bound(s, 64'd50);
               e.p95_time = percentile_bound(s, 64'd95);
               e.p99_time = percentile_bound(s, 64'd99);
            end
            expected_stats.push_back(e);
         end
         default: ;
      endcase
   endtask

   task automatic report(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch %s: expected %h actual %h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         record_enable = 1'b0;
         clear_stats();
         expected_stats.delete();
         error_count = 0;
         queries_seen = 0;
      end else begin
         // response checked against state before this edge's request
         if (rsp_valid) begin
            queries_seen++;
            if (expected_stats.size() == 0) begin
               error_count++;
               if (error_count <= 10) $display("unexpected response %h", rsp_data);
            end else begin
               e = expected_stats.pop_front();
               report("sample_count", e.sample_count, rsp_data.sample_count);
               report("total_time", e.total_time, rsp_data.total_time);
               report("min_time", e.min_time, rsp_data.min_time);
               report("max_time", e.max_time, rsp_data.max_time);
               report("p50_time", e.p50_time, rsp_data.p50_time);
               report("p95_time", e.p95_time, rsp_data.p95_time);
               report("p99_time", e.p99_time, rsp_data.p99_time);
            end
         end
         // a request at this edge still sees the old enable
         if (start && !busy) apply_request(req_data);
         if (csr_valid && csr_ready) record_enable = csr_data;
      end
      pending_queries = expected_stats.size();
   end

endmodule

### dv/testbench.sv
// top-level testbench driving requests and csr writes into the latency histogram monitor
`timescale 1ns / 100ps
module testbench;
   import lhm_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;
   int      error_count;
   int      pending_queries;
   int      queries_seen;
   int      request_total;
   bit      calm_stretch;

   latency_histogram_monitor_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   latency_histogram_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .error_count(error_count),
      .pending_queries(pending_queries), .queries_seen(queries_seen)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("[latency_histogram_monitor_top] ERROR");
      $finish;
   end

   function automatic logic [63:0] random_elapsed();
      logic [63:0] v;
      int shift;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = 64'($urandom_range(0, 3));
         1: v = 64'd1 << $urandom_range(0, 63);
         2: begin
            shift = $urandom_range(0, 63);
            v = (64'd1 << shift) + 64'd1;
         end
         3: v = v >> $urandom_range(0, 63);
         default: ;
      endcase
      return v;
   endfunction

   // start stays high after the request until the next send or drain
   task automatic send(input logic [1:0] op, input logic [2:0] stage, input logic [63:0] el);
      while (!calm_stretch && $urandom_range(0, 99) < 32) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{op: op, stage: stage, elapsed: el};
      @(posedge clock);
      while (busy) @(posedge clock);
      request_total++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_queries != 0) @(negedge clock);
      // a trailing record or clear may still be working
      repeat (NUM_STAGES * NUM_BUCKETS + 10) @(negedge clock);
   endtask

   task automatic write_enable(input logic v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n, input int query_pct);
      logic [1:0] op;
      int r;
      for (int i = 0; i < n; i++) begin
         calm_stretch = (i >= n / 3 && i < n / 2);
         r = $urandom_range(0, 99);
         if (r < query_pct) op = OP_QUERY;
         else if (r < query_pct + 2) op = OP_CLEAR;
         else if (r < query_pct + 4) op = 2'd3;
         else op = OP_RECORD;
         send(op, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4)),
              random_elapsed());
      end
      calm_stretch = 1'b0;
   endtask

   initial begin
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      calm_stretch = 1'b0;
      request_total = 0;
      reset = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: records while disabled are dropped
      send(OP_RECORD, 3'd0, 64'd5);
      send(OP_QUERY, 3'd0, 64'd0);
      drain();
      write_enable(1'b1);
      send(OP_RECORD, 3'd0, 64'd0);
      send(OP_RECORD, 3'd0, 64'd1);
      send(OP_RECORD, 3'd0, 64'd2);
      send(OP_RECORD, 3'd0, 64'd3);
      send(OP_RECORD, 3'd0, 64'h8000_0000);
      send(OP_RECORD, 3'd0, 64'h8000_0001);
      send(OP_RECORD, 3'd0, '1);
      send(OP_RECORD, 3'd1, '1);
      send(OP_RECORD, 3'd1, '1);
      send(OP_RECORD, 3'd4, 64'd7);
      send(OP_RECORD, 3'd5, 64'd9);
      send(OP_RECORD, 3'd7, 64'd9);
      send(2'd3, 3'd2, '1);
      send(OP_QUERY, 3'd0, '1);
      send(OP_QUERY, 3'd1, 64'd0);
      send(OP_QUERY, 3'd3, 64'd0);
      send(OP_QUERY, 3'd4, 64'd0);
      send(OP_QUERY, 3'd6, 64'd0);
      send(OP_QUERY, 3'd7, 64'd0);
      send(OP_CLEAR, 3'd7, '1);
      send(OP_QUERY, 3'd0, 64'd0);

      drain();
      random_phase(500, 12);
      drain();
      write_enable(1'b0);
      random_phase(150, 25);
      drain();
      write_enable(1'b1);
      random_phase(700, 10);
      drain();

      $display("run covered %0d requests and %0d query responses over several enable settings",
               request_total, queries_seen);
      if (error_count == 0) $display("[latency_histogram_monitor_top] OK");
      else $display("[latency_histogram_monitor_top] ERROR");
      $finish;
   end

endmodule
